@@ hw/rtl/dcp_pkg.sv @@
// Shared types and constants of the delta correlating prefetcher.
package dcp_pkg;

    localparam int ADDR_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRANULE_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_LIMIT  = 2'd2;

    localparam logic [3:0]        GRANULE_SHIFT_RST = 4'd5;
    localparam logic [4:0]        PARTIAL_MASK_RST  = 5'd8;
    localparam logic [ADDR_W-1:0] MEMORY_LIMIT_RST  = 32'hFFFF_FFFF;

    // One access; pc sits in the low bits when packed
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] pc;
    } access_t;

    // One prefetch candidate
    typedef struct packed {
        logic              last;
        logic [ADDR_W-1:0] address;
    } result_t;

    typedef struct packed {
        logic [3:0]        granule_shift;
        logic [4:0]        partial_mask_bits;
        logic [ADDR_W-1:0] memory_limit;
    } cfg_t;

endpackage

@@ hw/rtl/dcp_fifo.sv @@
// Two-entry queue that decouples the handshakes on its two sides.
module dcp_fifo #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Store incoming transfers
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hw/rtl/dcp_engine.sv @@
// Sequencer: table lookup, delta history update, pattern search and candidate emit.
module dcp_engine
    import dcp_pkg::*;
#(
    parameter int TABLE_ENTRIES    = 42,
    parameter int HISTORY_DEPTH    = 16,
    parameter int DELTA_LIMIT_BITS = 22
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  access_t in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int DW   = DELTA_LIMIT_BITS + 2;
    localparam int HW   = $clog2(HISTORY_DEPTH);
    localparam int NP   = HISTORY_DEPTH - 2;
    localparam int IXW  = $clog2(NP);
    localparam int CNTW = $clog2(NP + 1);
    localparam logic [ADDR_W-1:0] LIM = ADDR_W'(1) << DELTA_LIMIT_BITS;

    typedef logic [DW-1:0] delta_t;

    // One table row; hist[0] is the newest delta
    typedef struct packed {
        logic [ADDR_W-1:0]                 last_addr;
        logic [ADDR_W-1:0]                 last_pf;
        logic [HISTORY_DEPTH-1:0][DW-1:0] hist;
    } row_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MATCH, S_SEL, S_READ, S_DELTA, S_APPEND,
        S_SEARCH, S_PICK, S_WALK, S_PLAN, S_EMIT, S_WB
    } state_t;

    state_t            state_reg;
    logic              valid_reg [TABLE_ENTRIES];
    logic [ADDR_W-1:0] tag_reg   [TABLE_ENTRIES];
    logic [IW-1:0]     rank_reg  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] hitvec_reg;
    logic [TABLE_ENTRIES-1:0] vicvec_reg;
    access_t           item_reg;
    logic [IW-1:0]     idx_reg;
    logic              miss_reg;
    row_t              mem [TABLE_ENTRIES];
    row_t              rdata_reg;
    row_t              row_reg;
    logic              neg_reg;
    logic [ADDR_W-1:0] mag_reg;
    logic [NP-1:0]     full_reg;
    logic [NP-1:0]     part_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [CNTW-1:0]   ncand_reg;
    logic [CNTW-1:0]   k_reg;
    logic [CNTW-1:0]   first_reg;
    logic [IXW-1:0]    last_idx_reg;
    logic [ADDR_W-1:0] prev_reg;
    logic [ADDR_W-1:0] cand_reg [NP];
    logic [NP-1:0]     below_reg;
    logic [NP-1:0]     qual_reg;

    // Combinational helpers
    logic [TABLE_ENTRIES-1:0] sel_vec;
    logic              hit_any;
    logic [IW-1:0]     sel_idx;
    logic [IW-1:0]     sel_rank;
    row_t              base_row;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] shifted;
    logic [ADDR_W-1:0] clamped;
    delta_t            bmag;
    delta_t            bnew;
    delta_t            mask;
    logic [NP-1:0]     full_vec;
    logic [NP-1:0]     part_vec;
    logic [NP-1:0]     pick_vec;
    logic [CNTW-1:0]   pick_t;
    delta_t            walk_delta;
    logic [ADDR_W-1:0] walk_step;
    logic [ADDR_W-1:0] walk_next;
    logic [NP-1:0]     qual_vec;
    logic [IXW-1:0]    plan_last;
    logic [IXW-1:0]    k_idx;
    logic              k_is_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign k_idx     = k_reg[IXW-1:0];
    assign k_is_last = (k_idx == last_idx_reg);
    assign out_valid = (state_reg == S_EMIT) && qual_reg[k_idx];
    assign out_item  = '{last: k_is_last, address: cand_reg[k_idx]};

    // Choose the hit entry, else the least recently used one
    always_comb begin
        hit_any  = |hitvec_reg;
        sel_vec  = hit_any ? hitvec_reg : vicvec_reg;
        sel_idx  = '0;
        sel_rank = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (sel_vec[k]) begin
                sel_idx  = sel_idx | IW'(k);
                sel_rank = sel_rank | rank_reg[k];
            end
        end
    end

    // Delta arithmetic: difference, then scale, clamp and sign; a zero delta stays positive
    always_comb begin
        base_row = miss_reg ? '0 : rdata_reg;
        diff     = item_reg.address - base_row.last_addr;
        shifted  = mag_reg >> cfg.granule_shift;
        clamped  = (shifted > LIM) ? LIM : shifted;
        if (clamped == '0) begin
            clamped = ADDR_W'(1);
        end
        bmag = clamped[DW-1:0];
        bnew = (neg_reg && (shifted != '0)) ? (~bmag + delta_t'(1)) : bmag;
    end

    // Pair compares over all older positions, full and masked
    always_comb begin
        for (int j = 0; j < DW; j++) begin
            mask[j] = (j >= int'(cfg.partial_mask_bits));
        end
        for (int j = 0; j < NP; j++) begin
            full_vec[j] = (row_reg.hist[j+2] == row_reg.hist[1]) &&
                          (row_reg.hist[j+1] == row_reg.hist[0]);
            part_vec[j] = ((row_reg.hist[j+2] & mask) == (row_reg.hist[1] & mask)) &&
                          ((row_reg.hist[j+1] & mask) == (row_reg.hist[0] & mask));
        end
    end

    // Full matches take precedence over masked ones; among them the newest pair wins
    always_comb begin
        pick_vec = (|full_reg) ? full_reg : part_reg;
        pick_t   = '0;
        for (int j = NP - 1; j >= 0; j--) begin
            if (pick_vec[j]) begin
                pick_t = CNTW'(j + 1);
            end
        end
    end

    // Accumulate one delta per cycle into the next candidate
    always_comb begin
        walk_delta = row_reg.hist[HW'(cnt_reg - CNTW'(1))];
        walk_step  = ADDR_W'($signed(walk_delta)) << cfg.granule_shift;
        walk_next  = prev_reg + walk_step;
    end

    // Candidates to emit and the final one among them
    always_comb begin
        plan_last = '0;
        for (int j = 0; j < NP; j++) begin
            qual_vec[j] = below_reg[j] && (CNTW'(j) >= first_reg) &&
                          (CNTW'(j) < ncand_reg);
            if (qual_vec[j]) begin
                plan_last = IXW'(j);
            end
        end
    end

    // Table rows
    always_ff @(posedge aclk) begin
        if (state_reg == S_WB) begin
            mem[idx_reg] <= row_reg;
        end
        if (state_reg == S_READ) begin
            rdata_reg <= mem[idx_reg];
        end
    end

    // Sequencer with its working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                valid_reg[k] <= 1'b0;
                rank_reg[k]  <= IW'(k);
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        item_reg  <= in_item;
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    for (int k = 0; k < TABLE_ENTRIES; k++) begin
                        hitvec_reg[k] <= valid_reg[k] && (tag_reg[k] == item_reg.pc);
                        vicvec_reg[k] <= (rank_reg[k] == IW'(TABLE_ENTRIES - 1));
                    end
                    state_reg <= S_SEL;
                end
                S_SEL: begin
                    idx_reg  <= sel_idx;
                    miss_reg <= !hit_any;
                    for (int k = 0; k < TABLE_ENTRIES; k++) begin
                        if (sel_vec[k]) begin
                            rank_reg[k] <= '0;
                            if (!hit_any) begin
                                valid_reg[k] <= 1'b1;
                                tag_reg[k]   <= item_reg.pc;
                            end
                        end else if (rank_reg[k] < sel_rank) begin
                            rank_reg[k] <= rank_reg[k] + IW'(1);
                        end
                    end
                    state_reg <= S_READ;
                end
                S_READ: begin
                    state_reg <= S_DELTA;
                end
                S_DELTA: begin
                    row_reg   <= base_row;
                    neg_reg   <= diff[ADDR_W-1];
                    mag_reg   <= diff[ADDR_W-1] ? (~diff + ADDR_W'(1)) : diff;
                    state_reg <= S_APPEND;
                end
                S_APPEND: begin
                    row_reg.hist      <= {row_reg.hist[HISTORY_DEPTH-2:0], bnew};
                    row_reg.last_addr <= item_reg.address;
                    state_reg         <= S_SEARCH;
                end
                S_SEARCH: begin
                    full_reg  <= full_vec;
                    part_reg  <= part_vec;
                    state_reg <= S_PICK;
                end
                S_PICK: begin
                    cnt_reg   <= pick_t;
                    ncand_reg <= pick_t;
                    k_reg     <= '0;
                    first_reg <= '0;
                    prev_reg  <= item_reg.address;
                    state_reg <= (|pick_vec) ? S_WALK : S_WB;
                end
                S_WALK: begin
                    cand_reg[k_idx]  <= walk_next;
                    below_reg[k_idx] <= (walk_next < cfg.memory_limit);
                    if (walk_next == row_reg.last_pf) begin
                        first_reg <= k_reg + CNTW'(1);
                    end
                    prev_reg <= walk_next;
                    k_reg    <= k_reg + CNTW'(1);
                    cnt_reg  <= cnt_reg - CNTW'(1);
                    if (cnt_reg == CNTW'(1)) begin
                        state_reg <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    qual_reg     <= qual_vec;
                    last_idx_reg <= plan_last;
                    k_reg        <= first_reg;
                    state_reg    <= (|qual_vec) ? S_EMIT : S_WB;
                end
                S_EMIT: begin
                    if (!qual_reg[k_idx]) begin
                        k_reg <= k_reg + CNTW'(1);
                    end else if (out_ready) begin
                        row_reg.last_pf <= cand_reg[k_idx];
                        k_reg           <= k_reg + CNTW'(1);
                        if (k_is_last) begin
                            state_reg <= S_WB;
                        end
                    end
                end
                S_WB: begin
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/delta_correlating_prefetcher.sv @@
// Path to the first candidate: input queue, then the sequencer through match, select, read, delta,
//   append, search, pick, the walk over the deltas after the matched pair, plan and emit, which
//   steps past dropped candidates, then the result queue; stalls delay it further.
// The sequencer takes a new access only from idle, after write-back; it walks one delta per cycle.
// Reset (aresetn low at aclk, synchronous): table entries invalid, recency ranks in index
//   order, queues empty, configuration registers back to their defaults; table rows need no clearing.
// Top level: input queue, prefetch sequencer, result queue and configuration registers.
module delta_correlating_prefetcher
    import dcp_pkg::*;
#(
    parameter int TABLE_ENTRIES    = 42,
    parameter int HISTORY_DEPTH    = 16,
    parameter int DELTA_LIMIT_BITS = 22
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // access_pc [31:0], access_address [63:32]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // prefetch_address [31:0]
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata
);

    cfg_t    cfg_reg;
    logic    acc_valid;
    logic    acc_ready;
    access_t acc_item;
    logic    res_valid;
    logic    res_ready;
    result_t res_item;
    result_t out_item;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.granule_shift     <= GRANULE_SHIFT_RST;
            cfg_reg.partial_mask_bits <= PARTIAL_MASK_RST;
            cfg_reg.memory_limit      <= MEMORY_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GRANULE_SHIFT: cfg_reg.granule_shift     <= cfg_wdata[3:0];
                CFG_PARTIAL_MASK:  cfg_reg.partial_mask_bits <= cfg_wdata[4:0];
                CFG_MEMORY_LIMIT:  cfg_reg.memory_limit      <= cfg_wdata;
                default:           cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    dcp_fifo #(.WIDTH($bits(access_t))) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .out_data  (acc_item)
    );

    dcp_engine #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .HISTORY_DEPTH    (HISTORY_DEPTH),
        .DELTA_LIMIT_BITS (DELTA_LIMIT_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (acc_valid),
        .in_ready  (acc_ready),
        .in_item   (acc_item),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_item  (res_item)
    );

    dcp_fifo #(.WIDTH($bits(result_t))) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_item)
    );

    assign m_tdata = out_item.address;
    assign m_tlast = out_item.last;

endmodule

@@ tb/sv/delta_correlating_prefetcher_checker.sv @@
// Checker: predicts prefetch candidates from observed accesses and compares the result stream.
`timescale 1ns / 1ps

module delta_correlating_prefetcher_checker
    import dcp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [63:0]          s_tdata,   // access_pc [31:0], access_address [63:32]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          m_tdata,   // prefetch_address [31:0]
    input  logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata,
    output int                   mismatches,
    output int                   pending
);

    localparam int ENTRIES = 42;
    localparam int DEPTH   = 16;
    localparam logic [31:0] DELTA_CLAMP = 32'd1 << 22;

    cfg_t        cfg;
    logic        valid_q     [ENTRIES];
    logic [31:0] tag_q       [ENTRIES];
    logic [31:0] last_addr_q [ENTRIES];
    logic [31:0] last_pf_q   [ENTRIES];
    int          head_q      [ENTRIES];
    int          rank_q      [ENTRIES];
    int          deltas_q    [ENTRIES][DEPTH];
    result_t     expected_prefetches[$];

    assign pending = expected_prefetches.size();

    function automatic logic [31:0] mask_delta(input int d);
        logic [31:0] keep;
        keep = ~((32'd1 << cfg.partial_mask_bits) - 32'd1);
        return 32'(d) & 32'h00FF_FFFF & keep;
    endfunction

    function automatic void make_recent(input int e);
        int r;
        r = rank_q[e];
        for (int k = 0; k < ENTRIES; k++)
            if (rank_q[k] < r) rank_q[k]++;
        rank_q[e] = 0;
    endfunction

    // Table update and candidate prediction for one access
    function automatic void predict_prefetches(input logic [31:0] pc, input logic [31:0] addr);
        int          e, h, st, nh, i, k, found, ncand, first, n, a, b;
        bit          hit, neg;
        logic [31:0] diff, mag, prev, ma, mb;
        logic [31:0] cand [DEPTH];
        e = -1;
        found = 0;
        ncand = 0;
        first = 0;
        n = 0;
        hit = 0;
        for (k = 0; k < ENTRIES; k++)
            if (valid_q[k] && tag_q[k] == pc) e = k;
        if (e < 0) begin
            e = 0;
            for (k = 0; k < ENTRIES; k++)
                if (rank_q[k] > rank_q[e]) e = k;
            valid_q[e] = 1'b1;
            tag_q[e] = pc;
            last_addr_q[e] = '0;
            last_pf_q[e] = '0;
            head_q[e] = 0;
            for (k = 0; k < DEPTH; k++) deltas_q[e][k] = 0;
        end
        make_recent(e);
        h  = head_q[e];
        st = (h + DEPTH - 1) % DEPTH;
        nh = (h + 1) % DEPTH;
        // Signed delta in granules, clamped, zero stored as one
        diff = addr - last_addr_q[e];
        neg  = diff[31];
        mag  = neg ? -diff : diff;
        mag  = mag >> cfg.granule_shift;
        if (mag > DELTA_CLAMP) mag = DELTA_CLAMP;
        if (mag == 0) b = 1;
        else b = neg ? -int'(mag) : int'(mag);
        deltas_q[e][h] = b;
        a = deltas_q[e][st];
        head_q[e] = nh;
        last_addr_q[e] = addr;
        // Full match first, newest first
        i = st;
        while (i != nh) begin
            if (deltas_q[e][(i + DEPTH - 1) % DEPTH] == a && deltas_q[e][i] == b) begin
                found = i;
                hit = 1;
                break;
            end
            i = (i + DEPTH - 1) % DEPTH;
        end
        // Then the match with low bits ignored
        if (!hit) begin
            ma = mask_delta(a);
            mb = mask_delta(b);
            i = st;
            while (i != nh) begin
                if (mask_delta(deltas_q[e][(i + DEPTH - 1) % DEPTH]) == ma &&
                    mask_delta(deltas_q[e][i]) == mb) begin
                    found = i;
                    hit = 1;
                    break;
                end
                i = (i + DEPTH - 1) % DEPTH;
            end
        end
        if (!hit) return;
        // Accumulate the deltas that followed the pair
        prev = addr;
        k = (found + 1) % DEPTH;
        while (k != nh) begin
            prev = prev + (32'(deltas_q[e][k]) << cfg.granule_shift);
            cand[ncand] = prev;
            ncand++;
            if (prev == last_pf_q[e]) first = ncand;
            k = (k + 1) % DEPTH;
        end
        for (k = first; k < ncand; k++) begin
            if (cand[k] < cfg.memory_limit) begin
                expected_prefetches.push_back('{last: 1'b0, address: cand[k]});
                last_pf_q[e] = cand[k];
                n++;
            end
        end
        if (n > 0) expected_prefetches[expected_prefetches.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
        mismatches++;
    endtask

    initial mismatches = 0;

    // Track registers, predict on input transfers, compare output transfers
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            cfg.granule_shift     = GRANULE_SHIFT_RST;
            cfg.partial_mask_bits = PARTIAL_MASK_RST;
            cfg.memory_limit      = MEMORY_LIMIT_RST;
            for (int k = 0; k < ENTRIES; k++) begin
                valid_q[k] = 1'b0;
                tag_q[k] = '0;
                last_addr_q[k] = '0;
                last_pf_q[k] = '0;
                head_q[k] = 0;
                rank_q[k] = k;
                for (int j = 0; j < DEPTH; j++) deltas_q[k][j] = 0;
            end
            expected_prefetches.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_GRANULE_SHIFT: cfg.granule_shift = cfg_wdata[3:0];
                    CFG_PARTIAL_MASK:  cfg.partial_mask_bits = cfg_wdata[4:0];
                    CFG_MEMORY_LIMIT:  cfg.memory_limit = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_prefetches.size() == 0) begin
                    report_mismatch("unexpected transfer", '0, m_tdata);
                end else begin
                    want = expected_prefetches.pop_front();
                    if (m_tdata !== want.address)
                        report_mismatch("prefetch_address", want.address, m_tdata);
                    if (m_tlast !== want.last)
                        report_mismatch("last_of_run", 32'(want.last), 32'(m_tlast));
                end
            end
            if (s_tvalid && s_tready) predict_prefetches(s_tdata[31:0], s_tdata[63:32]);
        end
    end

endmodule

@@ tb/sv/delta_correlating_prefetcher_test.sv @@
// Top of the prefetcher testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module delta_correlating_prefetcher_test;
    import dcp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 150;
    localparam int PC_POOL     = 48;

    logic                 aclk, aresetn;
    logic                 s_tvalid, s_tready;
    logic [63:0]          s_tdata;   // access_pc [31:0], access_address [63:32]
    logic                 m_tvalid, m_tready;
    logic [31:0]          m_tdata;   // prefetch_address [31:0]
    logic                 m_tlast;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_wdata;
    int                   mismatches, pending;
    int                   tx_idle_pct, rx_idle_pct, cycles;
    bit                   rx_hold;
    logic [31:0]          pc_pool [PC_POOL];

    delta_correlating_prefetcher i_dut (.*);

    delta_correlating_prefetcher_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Abort a hung run
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                rx_hold = 0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one access and hold it until transfer; returns at a falling edge
    task automatic send_access(input logic [31:0] pc, input logic [31:0] addr);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {addr, pc};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Drain every expected result, then let accesses without results finish
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic stride_run(input logic [31:0] pc, input logic [31:0] base,
                              input logic [31:0] stride, input int count);
        for (int k = 0; k < count; k++) send_access(pc, base + stride * k);
    endtask

    // Mostly repeating delta patterns per pc, some noise accesses
    task automatic random_traffic(input int count);
        int          sent, len, plen;
        logic [31:0] pc, addr;
        logic [31:0] pattern [3];
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(4) == 0) begin
                send_access($urandom, $urandom);
                sent++;
            end else begin
                pc   = pc_pool[$urandom_range(PC_POOL - 1)];
                addr = $urandom;
                plen = $urandom_range(1, 3);
                len  = $urandom_range(5, 10);
                for (int k = 0; k < 3; k++) begin
                    pattern[k] = $urandom_range(1, 64) << $urandom_range(0, 8);
                    if ($urandom_range(1)) pattern[k] = -pattern[k];
                    if ($urandom_range(15) == 0) pattern[k] = $urandom;
                end
                for (int k = 0; k < len; k++) begin
                    addr = addr + pattern[k % plen];
                    send_access(pc, addr);
                end
                sent += len;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_GRANULE_SHIFT;
        cfg_wdata = '0;
        rx_hold = 0;
        tx_idle_pct = 27;
        rx_idle_pct = 84;
        for (int k = 0; k < PC_POOL; k++) pc_pool[k] = $urandom;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: strides, zero delta, negative, clamp, wrap
        stride_run(32'h0000_1000, 32'h0001_0000, 32'd64, 5);
        stride_run(32'hFFFF_FFFF, 32'h0002_0000, 32'd0, 4);
        stride_run(32'h0000_2000, 32'h0003_0000, -32'd128, 5);
        send_access(32'h0000_3000, 32'h0000_0000);
        send_access(32'h0000_3000, 32'h8000_0000);
        send_access(32'h0000_3000, 32'h0000_0000);
        send_access(32'h0000_3000, 32'hFFFF_FFFF);
        stride_run(32'h0000_1000, 32'hFFFF_FF00, 32'd64, 4);
        drain();

        // Widest mask, unit granule, every candidate dropped, stray index ignored
        write_reg(CFG_GRANULE_SHIFT, 32'd0);
        write_reg(CFG_PARTIAL_MASK, 32'd31);
        write_reg(CFG_MEMORY_LIMIT, 32'd0);
        write_reg(CFG_NONE, 32'hFFFF_FFFF);
        stride_run(32'h0000_4000, 32'h0000_0100, 32'd8, 5);
        drain();

        // Coarse granule (shift 12), no mask, upper half blocked
        write_reg(CFG_GRANULE_SHIFT, 32'd12);
        write_reg(CFG_PARTIAL_MASK, 32'd0);
        write_reg(CFG_MEMORY_LIMIT, 32'h8000_0000);
        random_traffic(25);
        drain();

        tx_idle_pct = 84;
        rx_idle_pct = 27;
        write_reg(CFG_GRANULE_SHIFT, 32'd3);
        write_reg(CFG_PARTIAL_MASK, 32'd16);
        write_reg(CFG_MEMORY_LIMIT, MEMORY_LIMIT_RST);
        random_traffic(25);
        drain();

        // No idling; fill the block while the receiver holds off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_GRANULE_SHIFT, 32'(GRANULE_SHIFT_RST));
        write_reg(CFG_PARTIAL_MASK, 32'(PARTIAL_MASK_RST));
        rx_hold = 1;
        stride_run(32'h0000_5000, 32'h0100_0000, 32'd32, 12);
        drain();
        random_traffic(25);
        drain();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
